// ===== rtl/core/fst_pkg.sv =====
package fst_pkg;

   // Field widths
   localparam int SPEED_W = 16;
   localparam int TEMP_W  = 16;
   localparam int MODE_W  = 2;
   localparam int CSR_IDX_W = 3;

   // Serial divider: dividend register, divisor/remainder width, step counter
   localparam int DVD_W = 32;
   localparam int DSR_W = 16;
   localparam int CNT_W = 6;

   // Serial multiplier
   localparam int MUL_W     = 16;
   localparam int MUL_CNT_W = 5;

   // Quotient bit counts per division; dividends are left aligned in DVD_W
   localparam int SLOPE_BITS = 23;   // speed span * 100 fits 23 bits
   localparam int SCALE_BITS = 32;   // full 32 bit product
   localparam int BLEND_BITS = 18;   // old + 2 * pick fits 18 bits
   localparam int SLOPE_PAD  = DVD_W - SLOPE_BITS;
   localparam int BLEND_PAD  = DVD_W - BLEND_BITS;

   // (span * 10000 / d) / 100 collapses to span * 100 / d
   localparam logic [SLOPE_BITS-1:0] SLOPE_MUL = SLOPE_BITS'(100);
   localparam logic [DSR_W-1:0]      SCALE_DIV = DSR_W'(100);
   localparam logic [DSR_W-1:0]      BLEND_DIV = DSR_W'(3);
   localparam logic [SPEED_W-1:0]    SETPOINT_FLOOR = SPEED_W'(4000);

   // Register reset values
   localparam logic [SPEED_W-1:0] SPEED_MIN_RST = SPEED_W'(4000);
   localparam logic [SPEED_W-1:0] SPEED_MAX_RST = SPEED_W'(12000);
   localparam logic [TEMP_W-1:0]  TEMP_LOW_RST  = TEMP_W'(250);
   localparam logic [TEMP_W-1:0]  TEMP_HIGH_RST = TEMP_W'(450);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_MIN    = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_MAX    = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_AMBIENT_LOW  = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_AMBIENT_HIGH = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] REG_BATTERY_LOW  = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] REG_BATTERY_HIGH = CSR_IDX_W'(5);

   // Drive mode codes
   localparam logic [MODE_W-1:0] MODE_REGULATE = MODE_W'(0);
   localparam logic [MODE_W-1:0] MODE_STOP     = MODE_W'(1);
   localparam logic [MODE_W-1:0] MODE_FULL     = MODE_W'(2);
   localparam logic [MODE_W-1:0] MODE_HOLD     = MODE_W'(3);

   typedef struct packed {
      logic signed [TEMP_W-1:0] ambient_temp;
      logic signed [TEMP_W-1:0] batt_temp;
      logic                     sensor_fault;
      logic                     rail_fault;
      logic                     maint_control;
      logic                     maint_mode;
      logic                     calib_mode;
   } req_type;

   typedef struct packed {
      logic [SPEED_W-1:0] fan_setpoint;
      logic [MODE_W-1:0]  drive_mode;
   } rsp_type;

   // Window settings for one mapping lane
   typedef struct packed {
      logic [SPEED_W-1:0]       speed_min;
      logic [SPEED_W-1:0]       dspeed;
      logic signed [TEMP_W-1:0] lo;
      logic signed [TEMP_W-1:0] hi;
   } map_cfg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAP,
      ST_BLEND,
      ST_EMIT
   } fst_state_type;

   typedef enum logic [1:0] {
      MS_IDLE,
      MS_SLOPE,
      MS_MULT,
      MS_SCALE
   } map_state_type;

endpackage

// ===== rtl/core/fan_setpoint_from_temperatures.sv =====
// Fan speed setpoint from ambient and battery temperatures.
//
// req_*: one transaction per periodic tick, carrying both temperatures and
// the fault/mode flags. rsp_*: one transaction per tick with the smoothed
// setpoint and the drive mode. Both use valid/stall; a transaction moves on
// an edge with valid high and stall low. csr_*: write-only register port,
// taken on any edge with csr_we high; indexes above 5 are ignored.
//
// From an accepted request to rsp_valid, both lanes run in parallel, each
// a 23-step serial slope division, a 16-step serial multiply and a 32-step
// serial divide by 100, then a shared 18-step serial divide by 3 blends the
// result into the stored setpoint. A lane whose window is empty skips its
// divisions and multiply and finishes in the cycle after acceptance.
// One tick is in work at a time; req_stall is high from acceptance until the
// result is loaded into the response register, so a new tick is taken only
// after that load, even while the previous response still waits. If
// rsp_stall holds the response, the finished tick waits and req_stall stays
// high.
// Reset (synchronous, active high) restores the register defaults, the
// setpoint to 4000 and drops all valids.
module fan_setpoint_from_temperatures import fst_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,

   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,

   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SPEED_W-1:0]   csr_wdata
);

   // configuration registers
   logic [SPEED_W-1:0] speed_min_ff, speed_min_in;
   logic [SPEED_W-1:0] speed_max_ff, speed_max_in;
   logic [TEMP_W-1:0]  ambient_low_ff, ambient_low_in;
   logic [TEMP_W-1:0]  ambient_high_ff, ambient_high_in;
   logic [TEMP_W-1:0]  battery_low_ff, battery_low_in;
   logic [TEMP_W-1:0]  battery_high_ff, battery_high_in;

   // sequencer and tick state
   fst_state_type      state_ff, state_in;
   logic [MODE_W-1:0]  mode_ff, mode_in;
   logic               amb_have_ff, amb_have_in;
   logic               bat_have_ff, bat_have_in;
   logic [SPEED_W-1:0] setpoint_ff, setpoint_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               accept;
   logic               blend_start;
   logic               out_load;

   logic [SPEED_W-1:0] dspeed;
   map_cfg_type        amb_cfg;
   map_cfg_type        bat_cfg;
   logic               amb_done;
   logic               bat_done;
   logic [SPEED_W-1:0] amb_speed;
   logic [SPEED_W-1:0] bat_speed;
   logic [SPEED_W-1:0] pick;
   logic [BLEND_BITS-1:0] blend_sum;
   logic               blend_done;
   logic [DVD_W-1:0]   blend_quo;
   logic [SPEED_W-1:0] blend_floor;
   logic [MODE_W-1:0]  req_mode;

   // register writes
   always_comb begin
      speed_min_in    = speed_min_ff;
      speed_max_in    = speed_max_ff;
      ambient_low_in  = ambient_low_ff;
      ambient_high_in = ambient_high_ff;
      battery_low_in  = battery_low_ff;
      battery_high_in = battery_high_ff;
      if (csr_we) begin
         case (csr_index)
            REG_SPEED_MIN:    speed_min_in    = csr_wdata;
            REG_SPEED_MAX:    speed_max_in    = csr_wdata;
            REG_AMBIENT_LOW:  ambient_low_in  = csr_wdata;
            REG_AMBIENT_HIGH: ambient_high_in = csr_wdata;
            REG_BATTERY_LOW:  battery_low_in  = csr_wdata;
            REG_BATTERY_HIGH: battery_high_in = csr_wdata;
            default:          speed_min_in    = speed_min_ff;
         endcase
      end
   end

   // lane settings; an inverted speed range counts as zero span
   always_comb begin
      dspeed = (speed_max_ff > speed_min_ff) ? speed_max_ff - speed_min_ff : '0;

      amb_cfg.speed_min = speed_min_ff;
      amb_cfg.dspeed    = dspeed;
      amb_cfg.lo        = ambient_low_ff;
      amb_cfg.hi        = ambient_high_ff;

      bat_cfg.speed_min = speed_min_ff;
      bat_cfg.dspeed    = dspeed;
      bat_cfg.lo        = battery_low_ff;
      bat_cfg.hi        = battery_high_ff;
   end

   // drive mode priority: hold, stop, full, regulate
   always_comb begin
      if (req_data.maint_control) begin
         req_mode = MODE_HOLD;
      end else if (req_data.maint_mode && req_data.calib_mode) begin
         req_mode = MODE_STOP;
      end else if (req_data.sensor_fault || req_data.rail_fault) begin
         req_mode = MODE_FULL;
      end else begin
         req_mode = MODE_REGULATE;
      end
   end

   // blend: (old + 2*max) / 3, floored
   always_comb begin
      pick        = (amb_speed >= bat_speed) ? amb_speed : bat_speed;
      blend_sum   = BLEND_BITS'(setpoint_ff) + {1'b0, pick, 1'b0};
      blend_floor = (blend_quo[BLEND_BITS-1:0] < BLEND_BITS'(SETPOINT_FLOOR))
                  ? SETPOINT_FLOOR : blend_quo[SPEED_W-1:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_MAP;
         end
         ST_MAP: begin
            if (amb_have_ff && bat_have_ff) state_in = ST_BLEND;
         end
         ST_BLEND: begin
            if (blend_done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall   = 1'b1;
      accept      = 1'b0;
      blend_start = 1'b0;
      out_load    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            accept    = req_valid;
         end
         ST_MAP: begin
            blend_start = amb_have_ff && bat_have_ff;
         end
         ST_BLEND: begin
            blend_start = 1'b0;
         end
         ST_EMIT: begin
            out_load = !rsp_valid_ff || !rsp_stall;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // tick bookkeeping and response register
   always_comb begin
      mode_in      = accept ? req_mode : mode_ff;
      amb_have_in  = accept ? 1'b0 : (amb_have_ff || amb_done);
      bat_have_in  = accept ? 1'b0 : (bat_have_ff || bat_done);
      setpoint_in  = out_load ? blend_floor : setpoint_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (out_load) begin
         rsp_data_in.fan_setpoint = blend_floor;
         rsp_data_in.drive_mode   = mode_ff;
         rsp_valid_in             = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_min_ff    <= SPEED_MIN_RST;
         speed_max_ff    <= SPEED_MAX_RST;
         ambient_low_ff  <= TEMP_LOW_RST;
         ambient_high_ff <= TEMP_HIGH_RST;
         battery_low_ff  <= TEMP_LOW_RST;
         battery_high_ff <= TEMP_HIGH_RST;
         state_ff        <= ST_IDLE;
         amb_have_ff     <= 1'b0;
         bat_have_ff     <= 1'b0;
         setpoint_ff     <= SETPOINT_FLOOR;
         rsp_valid_ff    <= 1'b0;
      end else begin
         speed_min_ff    <= speed_min_in;
         speed_max_ff    <= speed_max_in;
         ambient_low_ff  <= ambient_low_in;
         ambient_high_ff <= ambient_high_in;
         battery_low_ff  <= battery_low_in;
         battery_high_ff <= battery_high_in;
         state_ff        <= state_in;
         amb_have_ff     <= amb_have_in;
         bat_have_ff     <= bat_have_in;
         setpoint_ff     <= setpoint_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      rsp_data_ff <= rsp_data_in;
   end

   fst_map u_amb (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .cfg   (amb_cfg),
      .temp  (req_data.ambient_temp),
      .done  (amb_done),
      .speed (amb_speed)
   );

   fst_map u_bat (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .cfg   (bat_cfg),
      .temp  (req_data.batt_temp),
      .done  (bat_done),
      .speed (bat_speed)
   );

   fst_sdiv u_blend (
      .clock    (clock),
      .reset    (reset),
      .start    (blend_start),
      .dividend ({blend_sum, {BLEND_PAD{1'b0}}}),
      .divisor  (BLEND_DIV),
      .nbits    (CNT_W'(BLEND_BITS)),
      .done     (blend_done),
      .quotient (blend_quo)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff.fan_setpoint >= SETPOINT_FLOOR)
      else $error("setpoint below floor");

   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second transaction accepted while one is in work");

   a_blend_ready: assert property (@(posedge clock) disable iff (reset)
      blend_start |-> (amb_have_ff && bat_have_ff && state_ff == ST_MAP))
      else $error("blend started before both lanes finished");

   a_setpoint_hold: assert property (@(posedge clock) disable iff (reset)
      !out_load |=> $stable(setpoint_ff))
      else $error("setpoint changed without a response load");
`endif

endmodule

// ===== rtl/core/fst_sdiv.sv =====
// Restoring divider, one quotient bit per cycle.
// Dividend is left aligned; nbits steps leave the quotient in the low bits.
module fst_sdiv import fst_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DSR_W-1:0] divisor,
   input  logic [CNT_W-1:0] nbits,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVD_W-1:0] dvd_ff, dvd_in;
   logic [DSR_W-1:0] rem_ff, rem_in;
   logic [DSR_W-1:0] dsr_ff, dsr_in;
   logic [DVD_W-1:0] quo_ff, quo_in;

   logic [DSR_W:0]   trial;
   logic [DSR_W:0]   trial_sub;
   logic             fits;

   always_comb begin
      trial     = {rem_ff, dvd_ff[DVD_W-1]};
      trial_sub = trial - {1'b0, dsr_ff};
      fits      = trial >= {1'b0, dsr_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = nbits;
         dvd_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         quo_in  = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DVD_W-2:0], 1'b0};
         rem_in = fits ? trial_sub[DSR_W-1:0] : trial[DSR_W-1:0];
         quo_in = {quo_ff[DVD_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/core/fst_smul.sv =====
// Shift-add multiplier, one multiplier bit per cycle, 16 bit adder.
module fst_smul import fst_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [MUL_W-1:0]   mcand,
   input  logic [MUL_W-1:0]   mplier,
   output logic               done,
   output logic [2*MUL_W-1:0] product
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic [MUL_W-1:0]     mcand_ff, mcand_in;
   logic [MUL_W-1:0]     mpl_ff, mpl_in;
   logic [2*MUL_W-1:0]   prod_ff, prod_in;

   logic [MUL_W:0]       upper;

   always_comb begin
      upper = {1'b0, prod_ff[2*MUL_W-1:MUL_W]}
            + (mpl_ff[0] ? {1'b0, mcand_ff} : '0);

      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      mcand_in = mcand_ff;
      mpl_in   = mpl_ff;
      prod_in  = prod_ff;

      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = MUL_CNT_W'(MUL_W);
         mcand_in = mcand;
         mpl_in   = mplier;
         prod_in  = '0;
      end else if (busy_ff) begin
         prod_in = {upper, prod_ff[MUL_W-1:1]};
         mpl_in  = {1'b0, mpl_ff[MUL_W-1:1]};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == MUL_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff <= mcand_in;
      mpl_ff   <= mpl_in;
      prod_ff  <= prod_in;
   end

   assign done    = done_ff;
   assign product = prod_ff;

endmodule

// ===== rtl/core/fst_map.sv =====
// One mapping lane: clamp, slope = dspeed*100/span, offset = diff*slope/100.
// An empty window or inverted range gives speed_min in the cycle after start.
module fst_map import fst_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  map_cfg_type              cfg,
   input  logic signed [TEMP_W-1:0] temp,
   output logic                     done,
   output logic [SPEED_W-1:0]       speed
);

   map_state_type state_ff, state_in;

   logic [TEMP_W-1:0]  diff_ff, diff_in;
   logic [SPEED_W-1:0] speed_ff, speed_in;
   logic               done_ff, done_in;

   logic signed [TEMP_W:0]   span;
   logic                     window_open;
   logic signed [TEMP_W-1:0] temp_clamp;
   logic signed [TEMP_W:0]   clamp_off;
   logic [SLOPE_BITS-1:0]    slope_num;
   logic [SPEED_W-1:0]       slope_sat;

   logic             div_start;
   logic [DVD_W-1:0] div_dividend;
   logic [DSR_W-1:0] div_divisor;
   logic [CNT_W-1:0] div_nbits;
   logic             div_done;
   logic [DVD_W-1:0] div_quotient;

   logic               mul_start;
   logic               mul_done;
   logic [2*MUL_W-1:0] mul_product;

   always_comb begin
      span        = {cfg.hi[TEMP_W-1], cfg.hi} - {cfg.lo[TEMP_W-1], cfg.lo};
      window_open = !span[TEMP_W] && (span != '0);
      if (temp >= cfg.hi) begin
         temp_clamp = cfg.hi;
      end else if (temp <= cfg.lo) begin
         temp_clamp = cfg.lo;
      end else begin
         temp_clamp = temp;
      end
      clamp_off = {temp_clamp[TEMP_W-1], temp_clamp} - {cfg.lo[TEMP_W-1], cfg.lo};
      slope_num = SLOPE_BITS'(cfg.dspeed) * SLOPE_MUL;
      slope_sat = (|div_quotient[SLOPE_BITS-1:SPEED_W]) ? '1 : div_quotient[SPEED_W-1:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         MS_IDLE: begin
            if (start && window_open) state_in = MS_SLOPE;
         end
         MS_SLOPE: begin
            if (div_done) state_in = MS_MULT;
         end
         MS_MULT: begin
            if (mul_done) state_in = MS_SCALE;
         end
         MS_SCALE: begin
            if (div_done) state_in = MS_IDLE;
         end
         default: state_in = MS_IDLE;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      div_nbits    = '0;
      mul_start    = 1'b0;
      diff_in      = diff_ff;
      speed_in     = speed_ff;
      done_in      = 1'b0;
      case (state_ff)
         MS_IDLE: begin
            if (start) begin
               diff_in = clamp_off[TEMP_W-1:0];
               if (window_open) begin
                  div_start    = 1'b1;
                  div_dividend = {slope_num, {SLOPE_PAD{1'b0}}};
                  div_divisor  = span[DSR_W-1:0];
                  div_nbits    = CNT_W'(SLOPE_BITS);
               end else begin
                  speed_in = cfg.speed_min;
                  done_in  = 1'b1;
               end
            end
         end
         MS_SLOPE: begin
            mul_start = div_done;
         end
         MS_MULT: begin
            if (mul_done) begin
               div_start    = 1'b1;
               div_dividend = mul_product;
               div_divisor  = SCALE_DIV;
               div_nbits    = CNT_W'(SCALE_BITS);
            end
         end
         MS_SCALE: begin
            // offset never exceeds the speed span, so the sum fits
            if (div_done) begin
               speed_in = cfg.speed_min + div_quotient[SPEED_W-1:0];
               done_in  = 1'b1;
            end
         end
         default: begin
            done_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff  <= diff_in;
      speed_ff <= speed_in;
   end

   fst_sdiv u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .nbits    (div_nbits),
      .done     (div_done),
      .quotient (div_quotient)
   );

   fst_smul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (diff_ff),
      .mplier  (slope_sat),
      .done    (mul_done),
      .product (mul_product)
   );

   assign done  = done_ff;
   assign speed = speed_ff;

endmodule
